[hdl/rgb_breathing_fade_sequencer_top_macros.svh]
// Assertion macros for the RGB breathing fade sequencer.
`ifndef RGB_BREATHING_FADE_SEQUENCER_TOP_MACROS_SVH
`define RGB_BREATHING_FADE_SEQUENCER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RBFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define RBFS_NEVER(label, cond, msg) \
    `RBFS_ASSERT(label, !(cond), msg)

`endif

[hdl/rbfs_pkg.sv]
// Types and constants shared by the RGB breathing fade sequencer.
`default_nettype none

package rbfs_pkg;

    localparam int FIELD_W = 16;
    localparam int CNT_W   = 8;
    localparam int PHASE_W = 3;
    localparam int CHAN_W  = 2;
    localparam int WORK_W  = FIELD_W + CNT_W;
    localparam int IDX_W   = 1;
    localparam int ITER_W  = $clog2(WORK_W);

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [WORK_W-1:0]  work_t;
    typedef logic [IDX_W-1:0]   reg_idx_t;
    typedef logic [ITER_W-1:0]  iter_t;

    localparam reg_idx_t REG_STEP_COUNT        = 1'd0;
    localparam reg_idx_t REG_SECOND_FULL_SCALE = 1'd1;

    localparam cnt_t   STEP_COUNT_RESET = 8'd50;
    localparam field_t FULL_SCALE_RESET = 16'd1000;
    localparam cnt_t   CNT_MAX          = 8'd255;

    localparam phase_t PHASE_FIRST = 3'd0;
    localparam phase_t PHASE_LAST  = 3'd5;

    localparam chan_t CHAN_FIRST  = 2'd0;
    localparam chan_t CHAN_SECOND = 2'd1;
    localparam chan_t CHAN_THIRD  = 2'd2;

    localparam iter_t MUL_LAST = iter_t'(CNT_W - 1);
    localparam iter_t DIV_LAST = iter_t'(WORK_W - 1);

endpackage

`default_nettype wire

[hdl/rgb_breathing_fade_sequencer_top.sv]
// An accepted tick runs a shift-add multiply, then a restoring divide, then a result load;
// the result load waits on any output stall.
// No new tick is taken until the result beat of the last one is loaded, and the multiply
// and divide share the single 25-bit adder.
// Reset: asynchronous, active low; phase 0, step counter 50, step_count 50,
// second_full_scale 1000, no result pending.
`default_nettype none

module rgb_breathing_fade_sequencer_top
    import rbfs_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [FIELD_W-1:0]   cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FIELD_W-1:0]   period_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FIELD_W-1:0]        first_compare,
    output logic [FIELD_W-1:0]        second_compare,
    output logic [FIELD_W-1:0]        third_compare,
    output logic [PHASE_W-1:0]        fade_phase
);

`include "rgb_breathing_fade_sequencer_top_macros.svh"

    localparam logic [63:0] RAMP_LIMIT = (64'd1 << TIMER_BITS) - 64'd1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    cnt_t       step_count_reg;
    field_t     full_scale_reg;
    phase_t     phase_reg, phase_next;
    cnt_t       counter_reg, counter_next;
    chan_t      chan_reg;
    field_t     period_reg;
    iter_t      iter_reg, iter_next;
    work_t      work_reg, work_next;
    cnt_t       mcand_reg, mcand_next;
    cnt_t       rem_reg, rem_next;
    logic       out_valid_reg;
    field_t     first_reg, second_reg, third_reg;
    phase_t     out_phase_reg;

    logic       accept;
    logic       load_out;
    phase_t     ph_norm;
    logic       down;
    chan_t      chan_cur;
    field_t     mul_full;
    logic [CNT_W:0] rem_shift;
    work_t      alu_a, alu_b;
    logic       alu_cin;
    logic [WORK_W:0] alu_sum;
    logic       div_ok;
    field_t     ramp;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign ph_norm  = (phase_reg > PHASE_LAST) ? PHASE_FIRST : phase_reg;
    assign down     = !ph_norm[0];
    assign chan_cur = ph_norm[PHASE_W-1:1];

    always_comb
    begin
        if (down)
        begin
            counter_next = (counter_reg == '0) ? '0 : counter_reg - 1'b1;
            phase_next   = (counter_next == '0) ? ph_norm + 1'b1 : ph_norm;
        end
        else
        begin
            counter_next = (counter_reg == CNT_MAX) ? CNT_MAX : counter_reg + 1'b1;
            if (counter_next >= step_count_reg)
            begin
                phase_next = (ph_norm == PHASE_LAST) ? PHASE_FIRST : ph_norm + 1'b1;
            end
            else
            begin
                phase_next = ph_norm;
            end
        end
    end

    // Shared adder: shift-add multiply, then restoring divide.
    assign mul_full  = (chan_reg == CHAN_FIRST) ? period_reg : full_scale_reg;
    assign rem_shift = {rem_reg, work_reg[WORK_W-1]};
    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + (WORK_W+1)'(alu_cin);
    assign div_ok    = alu_sum[WORK_W];

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            alu_a   = work_t'(rem_shift);
            alu_b   = ~work_t'(step_count_reg);
            alu_cin = 1'b1;
        end
        else
        begin
            alu_a   = {work_reg[WORK_W-2:0], 1'b0};
            alu_b   = mcand_reg[CNT_W-1] ? work_t'(mul_full) : '0;
            alu_cin = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        work_next  = work_reg;
        mcand_next = mcand_reg;
        rem_next   = rem_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                    iter_next  = '0;
                    work_next  = '0;
                    mcand_next = counter_next;
                end
            end
            S_MUL:
            begin
                work_next  = alu_sum[WORK_W-1:0];
                mcand_next = {mcand_reg[CNT_W-2:0], 1'b0};
                iter_next  = iter_reg + 1'b1;
                if (iter_reg == MUL_LAST)
                begin
                    state_next = S_DIV;
                    iter_next  = '0;
                    rem_next   = '0;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ok ? alu_sum[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                work_next = {work_reg[WORK_W-2:0], div_ok};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if ((step_count_reg == '0) || ({40'd0, work_reg} > RAMP_LIMIT))
        begin
            ramp = RAMP_LIMIT[FIELD_W-1:0];
        end
        else
        begin
            ramp = work_reg[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_count_reg <= STEP_COUNT_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
            phase_reg      <= PHASE_FIRST;
            counter_reg    <= STEP_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_COUNT:        step_count_reg <= cfg_data[CNT_W-1:0];
                    REG_SECOND_FULL_SCALE: full_scale_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                counter_reg <= counter_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg  <= iter_next;
        work_reg  <= work_next;
        mcand_reg <= mcand_next;
        rem_reg   <= rem_next;
        if (accept)
        begin
            chan_reg   <= chan_cur;
            period_reg <= period_value;
        end
        if (load_out)
        begin
            first_reg     <= (chan_reg == CHAN_FIRST)  ? ramp : period_reg;
            second_reg    <= (chan_reg == CHAN_SECOND) ? ramp : full_scale_reg;
            third_reg     <= (chan_reg == CHAN_THIRD)  ? ramp : full_scale_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_compare  = first_reg;
    assign second_compare = second_reg;
    assign third_compare  = third_reg;
    assign fade_phase     = out_phase_reg;

    `RBFS_NEVER(a_phase_range, phase_reg > PHASE_LAST, "phase left its range")
    `RBFS_ASSERT(a_accept_starts_mul, accept |=> state_reg == S_MUL, "multiply not started")
    `RBFS_ASSERT(a_beat_from_done, $rose(out_valid_reg) |-> $past(load_out), "beat not loaded")
    `RBFS_NEVER(a_mul_iter_range, (state_reg == S_MUL) && (iter_reg > MUL_LAST), "mul overrun")
    `RBFS_NEVER(a_div_iter_range, (state_reg == S_DIV) && (iter_reg > DIV_LAST), "div overrun")

endmodule

`default_nettype wire

[tb/tb_rgb_breathing_fade_sequencer_top.sv]
// Testbench for the RGB breathing fade sequencer: predicted compare values checked per beat.
`timescale 1ns / 1ps

module tb_rgb_breathing_fade_sequencer_top
    import rbfs_pkg::*;
();

    typedef struct packed {
        field_t first;
        field_t second;
        field_t third;
        phase_t phase;
    } compare_set_t;

    class fade_tracker;
        cnt_t         step_count;
        field_t       full_scale;
        phase_t       phase;
        cnt_t         counter;
        compare_set_t expected_compares[$];
        int           errors;

        function new();
            step_count = STEP_COUNT_RESET;
            full_scale = FULL_SCALE_RESET;
            phase      = PHASE_FIRST;
            counter    = STEP_COUNT_RESET;
            errors     = 0;
        endfunction

        function void write_reg(reg_idx_t idx, field_t data);
            if (idx == REG_STEP_COUNT)
            begin
                step_count = cnt_t'(data);
            end
            else
            begin
                full_scale = data;
            end
        endfunction

        function int pending();
            return expected_compares.size();
        endfunction

        function void note_tick(field_t period);
            phase_t       ph;
            logic         down;
            chan_t        ch;
            field_t       full;
            field_t       ramp;
            logic [63:0]  q;
            compare_set_t e;

            ph = phase;
            if (ph > PHASE_LAST)
            begin
                ph = PHASE_FIRST;
            end
            down = ~ph[0];
            ch   = chan_t'(ph >> 1);

            if (down)
            begin
                if (counter != 0)
                begin
                    counter = counter - 1'b1;
                end
            end
            else if (counter != CNT_MAX)
            begin
                counter = counter + 1'b1;
            end

            full = (ch == CHAN_FIRST) ? period : full_scale;
            if (step_count == 0)
            begin
                ramp = '1;
            end
            else
            begin
                q    = (64'(counter) * 64'(full)) / 64'(step_count);
                ramp = (q > 64'hFFFF) ? '1 : field_t'(q);
            end

            e.first  = period;
            e.second = full_scale;
            e.third  = full_scale;
            case (ch)
                CHAN_FIRST:  e.first  = ramp;
                CHAN_SECOND: e.second = ramp;
                default:     e.third  = ramp;
            endcase

            if (down)
            begin
                if (counter == 0)
                begin
                    ph = ph + 1'b1;
                end
            end
            else if (counter >= step_count)
            begin
                ph = (ph == PHASE_LAST) ? PHASE_FIRST : ph + 1'b1;
            end
            phase   = ph;
            e.phase = ph;
            expected_compares.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_compare(compare_set_t got);
            compare_set_t e;

            if (expected_compares.size() == 0)
            begin
                $error("result beat with no tick outstanding");
                errors++;
                return;
            end
            e = expected_compares.pop_front();
            compare_field("first_compare", e.first, got.first);
            compare_field("second_compare", e.second, got.second);
            compare_field("third_compare", e.third, got.third);
            compare_field("fade_phase", e.phase, got.phase);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    reg_idx_t   cfg_index;
    field_t     cfg_data;
    logic       in_valid;
    logic       in_ready;
    field_t     period_value;
    logic       out_valid;
    logic       out_ready;
    field_t     first_compare;
    field_t     second_compare;
    field_t     third_compare;
    phase_t     fade_phase;

    fade_tracker tracker = new();
    bit          calm = 1'b0;
    bit          squeeze = 1'b0;
    int          ticks_sent = 0;

    rgb_breathing_fade_sequencer_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .period_value   (period_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_compare  (first_compare),
        .second_compare (second_compare),
        .third_compare  (third_compare),
        .fade_phase     (fade_phase)
    );

    always #5 clk = ~clk;

    task automatic write_config(field_t steps_data, field_t scale);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP_COUNT;
        cfg_data  <= steps_data;
        @(posedge clk);
        tracker.write_reg(REG_STEP_COUNT, steps_data);
        cfg_index <= REG_SECOND_FULL_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        tracker.write_reg(REG_SECOND_FULL_SCALE, scale);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_tick(field_t period);
        if (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!calm && $urandom_range(99) < 27);
        end
        in_valid     <= 1'b1;
        period_value <= period;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tracker.note_tick(period);
        ticks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic field_t pick_period();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return field_t'($urandom_range(65535));
        endcase
    endfunction

    function automatic field_t pick_steps();
        field_t upper;

        upper = field_t'($urandom_range(255)) << 8;
        case ($urandom_range(9))
            0:       return upper;
            1:       return upper | 16'd1;
            2:       return upper | 16'd255;
            3, 4, 5: return upper | field_t'($urandom_range(8, 1));
            6:       return upper | field_t'($urandom_range(255, 1));
            default: return upper | field_t'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic field_t pick_scale();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return FULL_SCALE_RESET;
            default: return field_t'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        int seg;
        int count;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_STEP_COUNT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        period_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_tick(16'h0000);
        send_tick(16'hFFFF);
        send_tick(16'h5555);
        send_tick(16'hAAAA);
        drain();

        // counter sits far above one step: ramp saturates
        write_config(16'd1, 16'hFFFF);
        repeat (8) send_tick(pick_period());
        drain();

        // step count of zero, upper data bits set
        write_config(16'hFF00, 16'h0000);
        repeat (8) send_tick(pick_period());
        drain();

        seg = 0;
        while (ticks_sent < 1020)
        begin
            write_config(pick_steps(), pick_scale());
            count = $urandom_range(60, 10);
            if (seg == 2)
            begin
                squeeze = 1'b1;
                count   = 80;
            end
            if (seg == 5)
            begin
                calm  = 1'b1;
                count = 150;
            end
            repeat (count) send_tick(pick_period());
            drain();
            calm = 1'b0;
            seg++;
        end

        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        bit squeezed;

        squeezed  = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (squeeze && !squeezed)
            begin
                // hold off long enough for the input side to back up
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (500) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 27);
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                tracker.check_compare('{first_compare, second_compare, third_compare,
                                        fade_phase});
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
